// ===== design/assert_macros.svh =====
// Assertion macros shared by the scale quantiser sequencer modules.
// Each macro expects the enclosing module to have ports named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent are checked on the same clock edge.
`define SQS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent is checked on the clock edge after the antecedent.
`define SQS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/sqs_pkg.sv =====
// Shared types, constants and lookup functions for the scale quantiser sequencer.
// No dependencies; used by sqs_scale, sqs_quant and scale_quantizer_sequencer_top.
package sqs_pkg;

   localparam int CHANNELS_DEFAULT = 16;
   localparam int CH_W             = 4;
   localparam int CV_W             = 17;
   localparam int MASK_W           = 12;
   localparam int STEP_W           = 4;
   localparam int DEGREES          = 12;
   localparam int COUNTS_W         = 12;
   localparam int CSR_IDX_W        = 1;

   typedef enum logic [1:0] {
      MODE_QUANT     = 2'd0,
      MODE_SEQ       = 2'd1,
      MODE_NEG       = 2'd2,
      MODE_QUANT_ALT = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE = 1'b0,
      CSR_MASK = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [CH_W-1:0]        channel;
      logic signed [CV_W-1:0] cv_in;
      logic signed [CV_W-1:0] root_cv;
      logic                   trigger_edge;
      logic                   trigger_connected;
      logic                   cv_connected;
      logic                   reset_edge;
   } item_type;

   // Degree list: number of entries (1..12) and each entry in Q.12 counts.
   typedef struct packed {
      logic [STEP_W-1:0]                      count;
      logic [DEGREES-1:0][COUNTS_W-1:0]       counts;
   } scale_list_type;

   typedef struct packed {
      logic held_we;
      logic prev_we;
      logic step_we;
   } update_type;

   // Semitone reached by the k-th step around the circle of fifths.
   function automatic logic [3:0] fifth_of(input logic [3:0] k);
      logic [3:0] s;
      case (k)
         4'd0:    s = 4'd0;
         4'd1:    s = 4'd7;
         4'd2:    s = 4'd2;
         4'd3:    s = 4'd9;
         4'd4:    s = 4'd4;
         4'd5:    s = 4'd11;
         4'd6:    s = 4'd6;
         4'd7:    s = 4'd1;
         4'd8:    s = 4'd8;
         4'd9:    s = 4'd3;
         4'd10:   s = 4'd10;
         4'd11:   s = 4'd5;
         default: s = 4'd0;
      endcase
      return s;
   endfunction

   // Semitone reflected about the axis of negative harmony.
   function automatic logic [3:0] mirror_of(input logic [3:0] s);
      logic [3:0] m;
      case (s)
         4'd0:    m = 4'd7;
         4'd1:    m = 4'd6;
         4'd2:    m = 4'd5;
         4'd3:    m = 4'd4;
         4'd4:    m = 4'd3;
         4'd5:    m = 4'd2;
         4'd6:    m = 4'd1;
         4'd7:    m = 4'd0;
         4'd8:    m = 4'd11;
         4'd9:    m = 4'd10;
         4'd10:   m = 4'd9;
         4'd11:   m = 4'd8;
         default: m = 4'd7;
      endcase
      return m;
   endfunction

   // A semitone in Q.12 counts, d/12 volt rounded to the nearest count.
   function automatic logic [COUNTS_W-1:0] degree_counts(input logic [3:0] d);
      logic [COUNTS_W-1:0] c;
      case (d)
         4'd0:    c = 12'd0;
         4'd1:    c = 12'd341;
         4'd2:    c = 12'd683;
         4'd3:    c = 12'd1024;
         4'd4:    c = 12'd1365;
         4'd5:    c = 12'd1707;
         4'd6:    c = 12'd2048;
         4'd7:    c = 12'd2389;
         4'd8:    c = 12'd2731;
         4'd9:    c = 12'd3072;
         4'd10:   c = 12'd3413;
         4'd11:   c = 12'd3755;
         default: c = 12'd0;
      endcase
      return c;
   endfunction

endpackage

// ===== design/sqs_scale.sv =====
// Configuration registers and the registered degree list built from them.
// Depends on sqs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sqs_scale (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sqs_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [sqs_pkg::MASK_W-1:0]           csr_data,
   output sqs_pkg::mode_type                    mode,
   output sqs_pkg::scale_list_type              list,
   output logic                                 busy
);

   sqs_pkg::mode_type              mode_ff;
   logic [sqs_pkg::MASK_W-1:0]     mask_ff;
   logic                           dirty_ff;
   logic                           dirty_in;
   sqs_pkg::scale_list_type        list_ff;
   sqs_pkg::scale_list_type        list_in;

   assign csr_ready = 1'b1;
   assign dirty_in  = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= sqs_pkg::MODE_QUANT;
         mask_ff  <= '0;
         dirty_ff <= 1'b0;
      end else begin
         dirty_ff <= dirty_in;
         if (dirty_in) begin
            case (csr_index)
               sqs_pkg::CSR_MODE: mode_ff <= sqs_pkg::mode_type'(csr_data[1:0]);
               sqs_pkg::CSR_MASK: mask_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // Compact the enabled degrees into list order; the rank of an enabled
   // candidate is the number of enabled candidates ahead of it.
   always_comb begin
      logic [sqs_pkg::DEGREES-1:0] en;
      logic [3:0]                  deg_of [sqs_pkg::DEGREES];
      logic [3:0]                  bit_idx;
      logic [3:0]                  fifth;
      logic [sqs_pkg::DEGREES-1:0] ahead;
      logic [3:0]                  rank;
      for (int i = 0; i < sqs_pkg::DEGREES; i++) begin
         fifth = sqs_pkg::fifth_of(4'(i));
         case (mode_ff)
            sqs_pkg::MODE_SEQ: begin
               bit_idx   = 4'(i);
               deg_of[i] = fifth;
            end
            sqs_pkg::MODE_NEG: begin
               bit_idx   = fifth;
               deg_of[i] = sqs_pkg::mirror_of(4'(i));
            end
            default: begin
               bit_idx   = fifth;
               deg_of[i] = 4'(i);
            end
         endcase
         en[i] = mask_ff[bit_idx];
      end
      list_in.counts = '0;
      for (int i = 0; i < sqs_pkg::DEGREES; i++) begin
         ahead = en & ((12'd1 << i) - 12'd1);
         rank  = 4'($countones(ahead));
         if (en[i]) begin
            list_in.counts[rank] = sqs_pkg::degree_counts(deg_of[i]);
         end
      end
      list_in.count = 4'($countones(en));
      if (en == '0) begin
         list_in.count = 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         list_ff.count  <= 4'd1;
         list_ff.counts <= '0;
      end else begin
         list_ff <= list_in;
      end
   end

   assign mode = mode_ff;
   assign list = list_ff;
   assign busy = dirty_ff;

   `SQS_ASSERT_NOW(a_list_count, 1'b1, (list_ff.count != 4'd0) && (list_ff.count <= 4'd12), "degree list length out of range")

endmodule

// ===== design/sqs_quant.sv =====
// Single-pass datapath: quantise or sequencer step for one item, plus state updates.
// Depends on sqs_pkg.
module sqs_quant (
   input  sqs_pkg::item_type                 item,
   input  logic                              in_range,
   input  sqs_pkg::mode_type                 mode,
   input  sqs_pkg::scale_list_type           list,
   input  logic signed [sqs_pkg::CV_W-1:0]   held_rd,
   input  logic signed [sqs_pkg::CV_W-1:0]   prev_rd,
   input  logic [sqs_pkg::STEP_W-1:0]        step_rd,
   output sqs_pkg::update_type               upd,
   output logic signed [sqs_pkg::CV_W-1:0]   held_wd,
   output logic [sqs_pkg::STEP_W-1:0]        step_wd,
   output logic signed [sqs_pkg::CV_W-1:0]   cv_out,
   output logic                              changed
);

   // List entry in counts; the entry just past the end is entry 0 an octave up.
   function automatic logic [12:0] entry_value(input sqs_pkg::scale_list_type l,
                                               input logic [3:0] idx);
      logic [12:0] v;
      if (idx == l.count) begin
         v = {1'b0, l.counts[0]} + 13'd4096;
      end else if (idx < 4'd12) begin
         v = {1'b0, l.counts[idx]};
      end else begin
         v = '0;
      end
      return v;
   endfunction

   logic                     seq_mode;
   logic                     sample;
   logic signed [16:0]       held_sel;
   logic [11:0]              r;
   logic [11:0]              f;
   logic [11:0]              diff;
   logic                     borrow;
   logic signed [18:0]       base;
   logic [15:0]              prod;
   logic [16:0]              rounded;
   logic [3:0]               note;
   logic [3:0]               step0;
   logic [3:0]               step1;
   logic signed [18:0]       sum_q;
   logic signed [18:0]       sum_s;
   logic signed [18:0]       result;
   logic signed [16:0]       sat;

   always_comb begin
      seq_mode = (mode == sqs_pkg::MODE_SEQ);
      sample   = !item.trigger_connected || item.trigger_edge;
      held_wd  = item.cv_in;
      held_sel = sample ? item.cv_in : held_rd;

      // Quantise: slot the fraction above the root into n equal parts.
      r       = item.root_cv[11:0];
      f       = held_sel[11:0];
      borrow  = f < r;
      diff    = f - r;
      base    = {{2{held_sel[16]}}, held_sel[16:12], r};
      base    = base - (borrow ? 19'sd4096 : 19'sd0);
      prod    = 16'(diff) * 16'(list.count);
      rounded = 17'(prod) + 17'd2048;
      note    = rounded[15:12];
      sum_q   = base + $signed({6'b0, entry_value(list, note)});

      // Sequencer step, clamped into the current list first.
      step0 = (step_rd >= list.count) ? 4'd0 : step_rd;
      step1 = step0;
      if (item.trigger_connected && item.trigger_edge) begin
         if (!item.cv_in[16] || !item.cv_connected) begin
            step1 = (step0 + 4'd1 == list.count) ? 4'd0 : step0 + 4'd1;
         end else begin
            step1 = (step0 == 4'd0) ? list.count - 4'd1 : step0 - 4'd1;
         end
      end
      if (item.reset_edge) begin
         step1 = 4'd0;
      end
      step_wd = step1;
      sum_s   = {{2{item.root_cv[16]}}, item.root_cv} + $signed({6'b0, entry_value(list, step1)});

      result = seq_mode ? sum_s : sum_q;
      if (result > 19'sd65535) begin
         sat = 17'sd65535;
      end else if (result < -19'sd65536) begin
         sat = -17'sd65536;
      end else begin
         sat = result[16:0];
      end

      upd     = '0;
      cv_out  = '0;
      changed = 1'b0;
      if (in_range) begin
         if (seq_mode && item.channel != '0) begin
            cv_out = prev_rd;
         end else begin
            cv_out      = sat;
            changed     = sat != prev_rd;
            upd.prev_we = sat != prev_rd;
            upd.held_we = !seq_mode && sample;
            upd.step_we = seq_mode;
         end
      end
   end

endmodule

// ===== design/scale_quantizer_sequencer_top.sv =====
// Scale quantiser sequencer top level: handshake, per-channel state, result register.
// Depends on sqs_pkg, sqs_scale, sqs_quant and assert_macros.svh.
//
// The block takes one request beat per clock cycle unless the request side is stalled,
// and returns exactly one response beat for each, in order: a beat is captured in the
// input register, worked through the single-pass quantiser and sequencer logic, and
// written to the response register, from which the response is offered; a new beat
// can enter the input register as the last one moves on to the response register.
// The per-channel held voltage and previous output live in flip-flops and are read and
// updated in the same pass, so consecutive beats on one channel need no forwarding.
// A full response register that is stalled holds the beat in the input register and
// stalls the request side in turn.
// Configuration writes on the csr_ port are always ready; during the write cycle and
// the cycle after it the request side is stalled while the registered degree list is
// rebuilt from the new mode and scale mask. Register 0 is the mode (0 quantise,
// 1 sequencer on channel 0 only, 2 negative harmony, 3 as 0) and register 1 the
// 12-bit circle-of-fifths mask.
`include "assert_macros.svh"

module scale_quantizer_sequencer_top #(
   parameter int CHANNELS = sqs_pkg::CHANNELS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sqs_pkg::CH_W-1:0]            req_channel,
   input  logic signed [sqs_pkg::CV_W-1:0]     req_cv_in,
   input  logic signed [sqs_pkg::CV_W-1:0]     req_root_cv,
   input  logic                                req_trigger_edge,
   input  logic                                req_trigger_connected,
   input  logic                                req_cv_connected,
   input  logic                                req_reset_edge,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sqs_pkg::CH_W-1:0]            rsp_out_channel,
   output logic signed [sqs_pkg::CV_W-1:0]     rsp_cv_out,
   output logic                                rsp_changed,
   // configuration write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sqs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sqs_pkg::MASK_W-1:0]          csr_data
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   sqs_pkg::mode_type                  mode;
   sqs_pkg::scale_list_type            list;
   logic                               list_busy;

   sqs_pkg::item_type                  item_ff;
   logic                               s1_valid_ff;
   logic                               s1_valid_in;
   logic                               req_accept;
   logic                               advance;

   logic signed [sqs_pkg::CV_W-1:0]    held_ff [CHANNELS];
   logic signed [sqs_pkg::CV_W-1:0]    prev_ff [CHANNELS];
   logic [sqs_pkg::STEP_W-1:0]         step_ff;

   logic [IDX_W-1:0]                   idx;
   logic                               in_range;
   logic signed [sqs_pkg::CV_W-1:0]    held_rd;
   logic signed [sqs_pkg::CV_W-1:0]    prev_rd;

   sqs_pkg::update_type                upd;
   logic signed [sqs_pkg::CV_W-1:0]    held_wd;
   logic [sqs_pkg::STEP_W-1:0]         step_wd;
   logic signed [sqs_pkg::CV_W-1:0]    cv_res;
   logic                               changed_res;

   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic [sqs_pkg::CH_W-1:0]           rsp_channel_ff;
   logic signed [sqs_pkg::CV_W-1:0]    rsp_cv_ff;
   logic                               rsp_changed_ff;

   sqs_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .mode      (mode),
      .list      (list),
      .busy      (list_busy)
   );

   // The input stage moves on whenever the response register is empty or is
   // being emptied on this edge.
   assign advance      = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = (s1_valid_ff && !advance) || csr_valid || list_busy;
   assign req_accept   = req_valid && !req_stall;
   assign s1_valid_in  = req_accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.channel           <= req_channel;
         item_ff.cv_in             <= req_cv_in;
         item_ff.root_cv           <= req_root_cv;
         item_ff.trigger_edge      <= req_trigger_edge;
         item_ff.trigger_connected <= req_trigger_connected;
         item_ff.cv_connected      <= req_cv_connected;
         item_ff.reset_edge        <= req_reset_edge;
      end
   end

   // Channels at or beyond CHANNELS touch no state and read as zero.
   assign in_range = {1'b0, item_ff.channel} < (sqs_pkg::CH_W + 1)'(CHANNELS);
   assign idx      = IDX_W'(item_ff.channel);
   assign held_rd  = in_range ? held_ff[idx] : '0;
   assign prev_rd  = in_range ? prev_ff[idx] : '0;

   sqs_quant u_quant (
      .item     (item_ff),
      .in_range (in_range),
      .mode     (mode),
      .list     (list),
      .held_rd  (held_rd),
      .prev_rd  (prev_rd),
      .step_rd  (step_ff),
      .upd      (upd),
      .held_wd  (held_wd),
      .step_wd  (step_wd),
      .cv_out   (cv_res),
      .changed  (changed_res)
   );

   // Per-channel state is updated on the same edge that loads the response.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            held_ff[c] <= '0;
            prev_ff[c] <= '0;
         end
         step_ff <= '0;
      end else if (advance) begin
         if (upd.held_we) begin
            held_ff[idx] <= held_wd;
         end
         if (upd.prev_we) begin
            prev_ff[idx] <= cv_res;
         end
         if (upd.step_we) begin
            step_ff <= step_wd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_channel_ff <= item_ff.channel;
         rsp_cv_ff      <= cv_res;
         rsp_changed_ff <= changed_res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_channel_ff;
   assign rsp_cv_out      = rsp_cv_ff;
   assign rsp_changed     = rsp_changed_ff;

   `SQS_ASSERT_NOW(a_step_range, 1'b1, step_ff < 4'd12, "sequencer step beyond the longest list")
   `SQS_ASSERT_NOW(a_no_accept_busy, list_busy, !req_accept, "beat accepted while degree list rebuilds")
   `SQS_ASSERT_NEXT(a_s1_holds, s1_valid_ff && rsp_valid_ff && rsp_stall, s1_valid_ff && $stable(item_ff), "input stage lost a beat under stall")

endmodule
